@@ rtl/bce_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bce_pkg;

    localparam int COUNT_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;

    // log2 format: integer part is the top set bit index, then LOG_FRAC fraction bits
    localparam int LOG_FRAC  = 32;
    localparam int LOG_INT_W = $clog2(COUNT_WIDTH);
    localparam int LOG_W     = LOG_INT_W + LOG_FRAC;
    // mantissa in Q1.31
    localparam int MANT_W    = 32;
    localparam int MANT_FRAC = MANT_W - 1;

    localparam int PROD_W    = COUNT_WIDTH + LOG_W;
    localparam int CLIP_BITS = 49;
    localparam int QUO_W     = CLIP_BITS;
    localparam int EXT_W     = CLIP_BITS + COUNT_WIDTH;
    localparam int TERM_W    = CLIP_BITS + 2;
    localparam int SUM_W     = TERM_W + 2;

    localparam int OUT_W       = 24;
    localparam int ROUND_SHIFT = LOG_FRAC - FRACTION_BITS;

    localparam int LOG_LAT  = LOG_FRAC + 1;
    localparam int DIV_LAT  = QUO_W + 1;
    localparam int PIPE_LAT = LOG_LAT + 2 + DIV_LAT + 1;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    typedef struct packed {
        logic                   undef;
        logic [COUNT_WIDTH-1:0] j00;
        logic [COUNT_WIDTH-1:0] j10;
        logic [COUNT_WIDTH-1:0] j01;
        logic [COUNT_WIDTH-1:0] j11;
        logic [COUNT_WIDTH-1:0] tot;
        logic [COUNT_WIDTH-1:0] m0;
        logic [COUNT_WIDTH-1:0] m1;
    } bce_item_t;

    typedef struct packed {
        logic valid;
        logic pop;
    } bce_qctl_t;

endpackage
`default_nettype wire

@@ rtl/binary_conditional_entropy.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one item per cycle while results are popped; the pipeline holds when the
// result register is full and not popped, and a 4-entry input queue absorbs the stall.
// Depth is set by the bit-per-stage log2 squaring chain and the bit-per-stage divider.
// Reset: asynchronous, active low; clears queue pointers and all valid bits.
module binary_conditional_entropy
    import bce_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [COUNT_WIDTH-1:0] joint_c0_t0,
    input  wire logic [COUNT_WIDTH-1:0] joint_c1_t0,
    input  wire logic [COUNT_WIDTH-1:0] joint_c0_t1,
    input  wire logic [COUNT_WIDTH-1:0] joint_c1_t1,
    input  wire logic [COUNT_WIDTH-1:0] total_count,
    input  wire logic [COUNT_WIDTH-1:0] test_count,
    output logic                        empty,
    input  wire logic                   pop,
    output logic signed [OUT_W-1:0]     entropy_value,
    output logic                        undefined_flag,
    output logic                        saturated_flag
);

    bce_item_t  head;
    logic       head_valid;
    bce_qctl_t  qctl;

    bce_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .joint_c0_t0 (joint_c0_t0),
        .joint_c1_t0 (joint_c1_t0),
        .joint_c0_t1 (joint_c0_t1),
        .joint_c1_t1 (joint_c1_t1),
        .total_count (total_count),
        .test_count  (test_count),
        .qctl_in     (qctl),
        .head        (head),
        .head_valid  (head_valid)
    );

    bce_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .head_valid     (head_valid),
        .qctl_out       (qctl),
        .empty          (empty),
        .pop            (pop),
        .entropy_value  (entropy_value),
        .undefined_flag (undefined_flag),
        .saturated_flag (saturated_flag)
    );

endmodule
`default_nettype wire

@@ rtl/bce_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bce_front
    import bce_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [COUNT_WIDTH-1:0] joint_c0_t0,
    input  wire logic [COUNT_WIDTH-1:0] joint_c1_t0,
    input  wire logic [COUNT_WIDTH-1:0] joint_c0_t1,
    input  wire logic [COUNT_WIDTH-1:0] joint_c1_t1,
    input  wire logic [COUNT_WIDTH-1:0] total_count,
    input  wire logic [COUNT_WIDTH-1:0] test_count,
    input  wire bce_qctl_t              qctl_in,
    output bce_item_t                   head,
    output logic                        head_valid
);

    bce_item_t               mem_reg [QDEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]       cnt_reg, cnt_next;
    bce_item_t               item;
    logic                    do_push;
    logic                    do_pop;
    logic [COUNT_WIDTH-1:0]  m0;

    assign m0 = total_count - test_count;

    // classify: zero total, test above total, or an empty marginal
    always_comb
    begin
        item.j00   = joint_c0_t0;
        item.j10   = joint_c1_t0;
        item.j01   = joint_c0_t1;
        item.j11   = joint_c1_t1;
        item.tot   = total_count;
        item.m0    = m0;
        item.m1    = test_count;
        item.undef = (total_count == '0) || (test_count > total_count) ||
                     (m0 == '0) || (test_count == '0);
    end

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = qctl_in.pop && qctl_in.valid && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("queue count above depth");

    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count missed a push");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != QCNT_W'(QDEPTH)) |-> (wr_ptr_reg - rd_ptr_reg == cnt_reg[QPTR_W-1:0]))
        else $error("queue pointers out of step with count");

endmodule
`default_nettype wire

@@ rtl/bce_log2.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bce_log2
    import bce_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   adv,
    input  wire logic [COUNT_WIDTH-1:0] x,
    output logic [LOG_W-1:0]            log_out
);

    logic [MANT_W-1:0]    y_reg [LOG_FRAC+1];
    logic [LOG_W-1:0]     r_reg [LOG_FRAC+1];
    logic [LOG_INT_W-1:0] msb;
    logic [COUNT_WIDTH+MANT_FRAC-1:0] norm;

    // top set bit index
    always_comb
    begin
        msb = '0;
        for (int b = 0; b < COUNT_WIDTH; b++)
        begin
            if (x[b])
            begin
                msb = LOG_INT_W'(b);
            end
        end
        norm = ({{MANT_FRAC{1'b0}}, x} << MANT_FRAC) >> msb;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            y_reg[0] <= norm[MANT_W-1:0];
            r_reg[0] <= {msb, {LOG_FRAC{1'b0}}};
        end
    end

    // one fraction bit per stage: square, then halve when it reaches 2
    for (genvar k = 0; k < LOG_FRAC; k++)
    begin : g_sq
        logic [2*MANT_W-1:0] sq;
        logic [MANT_W:0]     t;
        logic [LOG_W-1:0]    r_nx;

        always_comb
        begin
            sq   = y_reg[k] * y_reg[k];
            t    = sq[MANT_W+MANT_FRAC:MANT_FRAC];
            r_nx = r_reg[k];
            r_nx[LOG_FRAC-1-k] = t[MANT_W];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                y_reg[k+1] <= t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
                r_reg[k+1] <= r_nx;
            end
        end
    end

    assign log_out = r_reg[LOG_FRAC];

endmodule
`default_nettype wire

@@ rtl/bce_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bce_div
    import bce_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     adv,
    input  wire logic [PROD_W-1:0]        product,
    input  wire logic [COUNT_WIDTH-1:0]   tot,
    input  wire logic                     neg,
    output logic signed [TERM_W-1:0]      term
);

    logic [COUNT_WIDTH-1:0] rem_reg [QUO_W+1];
    logic [QUO_W-1:0]       quo_reg [QUO_W+1];
    logic [CLIP_BITS-1:0]   dvd_reg [QUO_W+1];
    logic [COUNT_WIDTH-1:0] tot_reg [QUO_W+1];
    logic                   neg_reg [QUO_W+1];
    logic                   clip_reg [QUO_W+1];
    logic [EXT_W-1:0]       ext;
    logic [EXT_W-1:0]       lim;
    logic [TERM_W-1:0]      mag;

    assign ext = EXT_W'(product);
    assign lim = {tot, {CLIP_BITS{1'b0}}};

    // bits above the clip point are already below tot unless clipped
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= ext[EXT_W-1:CLIP_BITS];
            dvd_reg[0]  <= ext[CLIP_BITS-1:0];
            quo_reg[0]  <= '0;
            tot_reg[0]  <= tot;
            neg_reg[0]  <= neg;
            clip_reg[0] <= (ext >= lim);
        end
    end

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        logic [COUNT_WIDTH:0]   sh;
        logic                   ge;
        logic [COUNT_WIDTH:0]   diff;
        logic [QUO_W-1:0]       q_nx;

        always_comb
        begin
            sh   = {rem_reg[k], dvd_reg[k][QUO_W-1-k]};
            ge   = (sh >= {1'b0, tot_reg[k]});
            diff = sh - {1'b0, tot_reg[k]};
            q_nx = quo_reg[k];
            q_nx[QUO_W-1-k] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k+1]  <= ge ? diff[COUNT_WIDTH-1:0] : sh[COUNT_WIDTH-1:0];
                quo_reg[k+1]  <= q_nx;
                dvd_reg[k+1]  <= dvd_reg[k];
                tot_reg[k+1]  <= tot_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                clip_reg[k+1] <= clip_reg[k];
            end
        end
    end

    always_comb
    begin
        mag  = clip_reg[QUO_W] ? (TERM_W'(1) << CLIP_BITS) : TERM_W'(quo_reg[QUO_W]);
        term = neg_reg[QUO_W] ? -$signed(mag) : $signed(mag);
    end

endmodule
`default_nettype wire

@@ rtl/bce_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bce_back
    import bce_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bce_item_t         head,
    input  wire logic              head_valid,
    output bce_qctl_t              qctl_out,
    output logic                   empty,
    input  wire logic              pop,
    output logic signed [OUT_W-1:0] entropy_value,
    output logic                   undefined_flag,
    output logic                   saturated_flag
);

    localparam int MAG_IDX  = LOG_LAT;
    localparam int PROD_IDX = LOG_LAT + 1;

    logic                    adv;
    logic [PIPE_LAT-1:0]     valid_reg;
    logic                    out_valid_reg;
    bce_item_t               side_reg [LOG_LAT];

    logic [LOG_W-1:0]        lg [6];
    logic [COUNT_WIDTH-1:0]  lin [6];

    logic [LOG_W-1:0]        mag_reg [4];
    logic                    neg_reg [4];
    logic [COUNT_WIDTH-1:0]  jm_reg [4];
    logic [COUNT_WIDTH-1:0]  tot_m_reg;
    logic                    und_m_reg;

    logic [PROD_W-1:0]       prod_reg [4];
    logic                    negp_reg [4];
    logic [COUNT_WIDTH-1:0]  tot_p_reg;
    logic                    und_p_reg;

    logic                    und_d_reg [DIV_LAT];
    logic signed [TERM_W-1:0] term [4];

    logic signed [SUM_W-1:0] sum_reg;
    logic                    und_s_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] rnd;
    logic signed [SUM_W-1:0] v;
    logic signed [OUT_W-1:0] val_next;
    logic                    sat_next;

    logic signed [OUT_W-1:0] value_reg;
    logic                    und_reg;
    logic                    sat_reg;

    assign adv            = !out_valid_reg || pop;
    assign qctl_out.valid = head_valid;
    assign qctl_out.pop   = adv;

    assign lin[0] = head.m0;
    assign lin[1] = head.m1;
    assign lin[2] = head.j00;
    assign lin[3] = head.j10;
    assign lin[4] = head.j01;
    assign lin[5] = head.j11;

    for (genvar g = 0; g < 6; g++)
    begin : g_log
        bce_log2 u_log (
            .clk     (clk),
            .adv     (adv),
            .x       (lin[g]),
            .log_out (lg[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= head;
            for (int s = 1; s < LOG_LAT; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    // term sign and |log2 m - log2 j|
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int t = 0; t < 4; t++)
            begin
                neg_reg[t] <= lg[2+t] > lg[t/2];
                mag_reg[t] <= (lg[2+t] > lg[t/2]) ? lg[2+t] - lg[t/2] : lg[t/2] - lg[2+t];
            end
            jm_reg[0] <= side_reg[LOG_LAT-1].j00;
            jm_reg[1] <= side_reg[LOG_LAT-1].j10;
            jm_reg[2] <= side_reg[LOG_LAT-1].j01;
            jm_reg[3] <= side_reg[LOG_LAT-1].j11;
            tot_m_reg <= side_reg[LOG_LAT-1].tot;
            und_m_reg <= side_reg[LOG_LAT-1].undef;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int t = 0; t < 4; t++)
            begin
                prod_reg[t] <= PROD_W'(jm_reg[t]) * PROD_W'(mag_reg[t]);
                negp_reg[t] <= neg_reg[t];
            end
            tot_p_reg <= tot_m_reg;
            und_p_reg <= und_m_reg;
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_div
        bce_div u_div (
            .clk     (clk),
            .adv     (adv),
            .product (prod_reg[g]),
            .tot     (tot_p_reg),
            .neg     (negp_reg[g]),
            .term    (term[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            und_d_reg[0] <= und_p_reg;
            for (int s = 1; s < DIV_LAT; s++)
            begin
                und_d_reg[s] <= und_d_reg[s-1];
            end
        end
    end

    always_comb
    begin
        sum_next = SUM_W'(term[0]) + SUM_W'(term[1]) + SUM_W'(term[2]) + SUM_W'(term[3]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg   <= sum_next;
            und_s_reg <= und_d_reg[DIV_LAT-1];
        end
    end

    // round half up, then clip to the output range
    always_comb
    begin
        rnd      = sum_reg + (SUM_W'(1) << (ROUND_SHIFT - 1));
        v        = rnd >>> ROUND_SHIFT;
        sat_next = 1'b0;
        if (v > SUM_W'((1 << (OUT_W - 1)) - 1))
        begin
            val_next = {1'b0, {(OUT_W-1){1'b1}}};
            sat_next = 1'b1;
        end
        else if (v < -(SUM_W'(1) << (OUT_W - 1)))
        begin
            val_next = {1'b1, {(OUT_W-1){1'b0}}};
            sat_next = 1'b1;
        end
        else
        begin
            val_next = v[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            value_reg <= und_s_reg ? '0 : val_next;
            sat_reg   <= und_s_reg ? 1'b0 : sat_next;
            und_reg   <= und_s_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg     <= {valid_reg[PIPE_LAT-2:0], head_valid};
            out_valid_reg <= valid_reg[PIPE_LAT-1];
        end
    end

    assign empty          = !out_valid_reg;
    assign entropy_value  = value_reg;
    assign undefined_flag = und_reg;
    assign saturated_flag = sat_reg;

    a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && und_reg) |-> (value_reg == '0 && !sat_reg))
        else $error("undefined result not forced to zero");

    a_sat_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && sat_reg) |->
            (value_reg == {1'b0, {(OUT_W-1){1'b1}}} || value_reg == {1'b1, {(OUT_W-1){1'b0}}}))
        else $error("saturated result not at range limit");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(valid_reg) && $stable(value_reg)))
        else $error("pipeline moved while stalled");

    a_mag_align: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && valid_reg[PROD_IDX-1]) |=> valid_reg[PROD_IDX])
        else $error("valid lost between magnitude and product stages");

    a_stage_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && valid_reg[MAG_IDX-1]) |=> valid_reg[MAG_IDX])
        else $error("valid lost after log stages");

endmodule
`default_nettype wire

@@ dv/tb_binary_conditional_entropy.sv @@
`timescale 1ns / 1ps
module tb_binary_conditional_entropy;
    import bce_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 300;
    localparam int RAND_ITEMS  = 1830;

    typedef struct {
        logic [COUNT_WIDTH-1:0] j00;
        logic [COUNT_WIDTH-1:0] j10;
        logic [COUNT_WIDTH-1:0] j01;
        logic [COUNT_WIDTH-1:0] j11;
        logic [COUNT_WIDTH-1:0] tot;
        logic [COUNT_WIDTH-1:0] tst;
    } table_t;

    typedef struct {
        logic signed [OUT_W-1:0] value;
        logic                    undef;
        logic                    sat;
    } entropy_t;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic [COUNT_WIDTH-1:0] joint_c0_t0, joint_c1_t0, joint_c0_t1, joint_c1_t1;
    logic [COUNT_WIDTH-1:0] total_count, test_count;
    logic empty;
    logic pop;
    logic signed [OUT_W-1:0] entropy_value;
    logic undefined_flag;
    logic saturated_flag;

    table_t   tables_q[$];
    entropy_t entropy_q[$];
    int       send_idle;
    int       recv_stall;
    int       errors;
    int       quiet_cycles;
    logic     in_beat;

    binary_conditional_entropy u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .joint_c0_t0(joint_c0_t0), .joint_c1_t0(joint_c1_t0),
        .joint_c0_t1(joint_c0_t1), .joint_c1_t1(joint_c1_t1),
        .total_count(total_count), .test_count(test_count),
        .empty(empty), .pop(pop), .entropy_value(entropy_value),
        .undefined_flag(undefined_flag), .saturated_flag(saturated_flag)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // log2 of x (x >= 1) with 32 fraction bits, one bit per squaring
    function automatic logic [63:0] log2_q32(input logic [63:0] x);
        int n;
        logic [63:0] y;
        logic [63:0] r;
        n = 0;
        for (int b = 0; b < 64; b++)
            if (x[b])
                n = b;
        y = (n >= 31) ? (x >> (n - 31)) : (x << (31 - n));
        r = 64'(n) << 32;
        for (int i = 31; i >= 0; i--)
        begin
            y = (y * y) >> 31;
            if (y >= 64'h1_0000_0000)
            begin
                r[i] = 1'b1;
                y = y >> 1;
            end
        end
        return r;
    endfunction

    function automatic logic signed [63:0] entropy_term(input logic [63:0] j,
                                                        input logic [63:0] m,
                                                        input logic [63:0] tot);
        logic [63:0]  lm, lj;
        logic [127:0] prod, lim, q;
        logic         neg;
        if (j == 0)
            return 0;
        lm   = log2_q32(m);
        lj   = log2_q32(j);
        neg  = lj > lm;
        prod = 128'(j) * 128'(neg ? (lj - lm) : (lm - lj));
        lim  = 128'(tot) << CLIP_BITS;
        q    = (prod >= lim) ? (128'(1) << CLIP_BITS) : (prod / 128'(tot));
        return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function automatic entropy_t predict_entropy(input table_t t);
        entropy_t e;
        logic [63:0] m0, m1;
        logic signed [63:0] sum, v;
        e.value = '0;
        e.undef = 1'b0;
        e.sat   = 1'b0;
        m0 = 64'(t.tot) - 64'(t.tst);
        m1 = 64'(t.tst);
        if (t.tot == 0 || t.tst > t.tot || m0 == 0 || m1 == 0)
        begin
            e.undef = 1'b1;
            return e;
        end
        sum = entropy_term(64'(t.j00), m0, 64'(t.tot)) + entropy_term(64'(t.j10), m0, 64'(t.tot))
            + entropy_term(64'(t.j01), m1, 64'(t.tot)) + entropy_term(64'(t.j11), m1, 64'(t.tot));
        v = (sum + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        if (v > 64'sd8388607)
        begin
            v = 64'sd8388607;
            e.sat = 1'b1;
        end
        else if (v < -64'sd8388608)
        begin
            v = -64'sd8388608;
            e.sat = 1'b1;
        end
        e.value = v[OUT_W-1:0];
        return e;
    endfunction

    function automatic table_t make_table(input logic [31:0] a, b, c, d, tot, tst);
        table_t t;
        t.j00 = a; t.j10 = b; t.j01 = c; t.j11 = d; t.tot = tot; t.tst = tst;
        return t;
    endfunction

    function automatic table_t random_table();
        table_t t;
        int     kind;
        logic [31:0] m0;
        kind = $urandom_range(99);
        if (kind < 10)
            return make_table($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        case ($urandom_range(9))
            0, 1, 2, 3, 4: t.tot = $urandom_range(64, 2);
            5, 6, 7:       t.tot = $urandom_range(65535, 2);
            default:       t.tot = $urandom_range(32'hFFFF_FFFF, 2);
        endcase
        t.tst = $urandom_range(t.tot - 1, 1);
        if (kind < 14)
            t.tst = (kind < 12) ? t.tot : 0;
        else if (kind < 16)
            t.tot = 0;
        m0 = t.tot - t.tst;
        t.j00 = $urandom_range(m0, 0);
        t.j10 = m0 - t.j00;
        t.j01 = $urandom_range(t.tst, 0);
        t.j11 = t.tst - t.j01;
        if (kind >= 90)
        begin
            // broken table: some joint above its marginal
            t.j00 = $urandom;
            t.j11 = $urandom_range(20);
        end
        return t;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, want %0d", what, got, want);
        errors++;
    endtask

    // driver: change inputs on the falling edge
    always @(negedge clk)
    begin
        table_t t;
        logic   nxt;
        if (rst_n)
        begin
            if (!push || in_beat)
            begin
                nxt = (tables_q.size() != 0) && ($urandom_range(99) >= send_idle);
                if (nxt)
                begin
                    t = tables_q.pop_front();
                    joint_c0_t0 <= t.j00;
                    joint_c1_t0 <= t.j10;
                    joint_c0_t1 <= t.j01;
                    joint_c1_t1 <= t.j11;
                    total_count <= t.tot;
                    test_count  <= t.tst;
                end
                push <= nxt;
            end
            pop <= ($urandom_range(99) >= recv_stall);
        end
    end

    // monitor: sample on the rising edge
    always @(posedge clk)
    begin
        entropy_t e;
        logic     got_beat;
        got_beat = 1'b0;
        if (rst_n)
        begin
            if (push && !full)
            begin
                entropy_q.push_back(predict_entropy(make_table(joint_c0_t0, joint_c1_t0,
                    joint_c0_t1, joint_c1_t1, total_count, test_count)));
                got_beat = 1'b1;
            end
            if (pop && !empty)
            begin
                got_beat = 1'b1;
                if (entropy_q.size() == 0)
                begin
                    $display("mismatch: result beat with nothing expected");
                    errors++;
                end
                else
                begin
                    e = entropy_q.pop_front();
                    if (entropy_value !== e.value)
                        report_mismatch("entropy_value", entropy_value, e.value);
                    if (undefined_flag !== e.undef)
                        report_mismatch("undefined_flag", undefined_flag, e.undef);
                    if (saturated_flag !== e.sat)
                        report_mismatch("saturated_flag", saturated_flag, e.sat);
                end
            end
            quiet_cycles <= got_beat ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb_binary_conditional_entropy: done, errors");
                $finish;
            end
        end
        in_beat <= rst_n && push && !full;
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        in_beat = 1'b0;
        errors = 0;
        quiet_cycles = 0;
        send_idle = 0;
        recv_stall = 0;
        {joint_c0_t0, joint_c1_t0, joint_c0_t1, joint_c1_t1, total_count, test_count} = '0;

        // directed corners
        tables_q.push_back(make_table(0, 0, 0, 0, 0, 0));
        tables_q.push_back(make_table(1, 1, 1, 1, 0, 0));
        tables_q.push_back(make_table(1, 1, 1, 1, 4, 5));
        tables_q.push_back(make_table(2, 2, 0, 0, 4, 0));
        tables_q.push_back(make_table(0, 0, 2, 2, 4, 4));
        tables_q.push_back(make_table(1, 0, 0, 1, 2, 1));
        tables_q.push_back(make_table(1, 1, 1, 1, 4, 2));
        tables_q.push_back(make_table(0, 1, 1, 0, 2, 1));
        tables_q.push_back(make_table(3, 5, 7, 1, 16, 8));
        tables_q.push_back(make_table(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1,
                                      32'hFFFF_FFFF, 1));
        tables_q.push_back(make_table(1, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      32'hFFFF_FFFF, 32'hFFFF_FFFE));
        tables_q.push_back(make_table(32'h8000_0000, 32'h7FFF_FFFE, 1, 0,
                                      32'hFFFF_FFFF, 1));
        tables_q.push_back(make_table(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        tables_q.push_back(make_table(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000));
        tables_q.push_back(make_table(5, 0, 0, 0, 2, 1));
        tables_q.push_back(make_table(32'hFFFF_FFFF, 0, 0, 0, 2, 1));
        tables_q.push_back(make_table(0, 0, 0, 32'hFFFF_FFFF, 3, 1));
        tables_q.push_back(make_table(0, 0, 0, 0, 10, 3));
        tables_q.push_back(make_table(1, 0, 0, 0, 1, 0));
        tables_q.push_back(make_table(1, 2, 3, 4, 32'hFFFF_FFFF, 0));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 62; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 62; end
                default: begin send_idle = 34; recv_stall = 34; end
            endcase
            for (int k = 0; k < RAND_ITEMS / 4; k++)
                tables_q.push_back(random_table());
            while (tables_q.size() != 0)
                @(posedge clk);
        end

        while (push || entropy_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0 && entropy_q.size() == 0)
            $display("tb_binary_conditional_entropy: done, clean");
        else
            $display("tb_binary_conditional_entropy: done, errors");
        $finish;
    end

endmodule
